>>> rtl/bcs_pkg.sv
package bcs_pkg;

    localparam int STATE_W = 5;
    localparam int EVENT_W = 4;
    localparam int PATH_W = 4;
    localparam int TICKS_W = 15;
    localparam int OPENFILL_W = 16;

    localparam logic [STATE_W-1:0] SETTLE_TICKS = 5'd20;
    localparam logic [STATE_W-1:0] SETTLE_CLOSE_AT = 5'd2;
    localparam logic [TICKS_W-1:0] FILL_MAX = 15'h7FFF;
    localparam logic [OPENFILL_W-1:0] OPENFILL_MAX = 16'hFFFF;
    localparam logic [TICKS_W-1:0] OPENFILL_LIMIT_RESET = 15'd300;

    localparam logic [EVENT_W-1:0] EV_START = 4'd0;
    localparam logic [EVENT_W-1:0] EV_RESUME = 4'd1;
    localparam logic [EVENT_W-1:0] EV_STOP = 4'd2;
    localparam logic [EVENT_W-1:0] EV_PAUSE = 4'd3;
    localparam logic [EVENT_W-1:0] EV_RESET = 4'd4;
    localparam logic [EVENT_W-1:0] EV_T50MS = 4'd5;
    localparam logic [EVENT_W-1:0] EV_T500MS = 4'd6;
    localparam logic [EVENT_W-1:0] EV_T1S = 4'd7;
    localparam logic [EVENT_W-1:0] EV_CURRENT = 4'd8;
    localparam logic [EVENT_W-1:0] EV_STOP1 = 4'd9;
    localparam logic [EVENT_W-1:0] EV_STOP2 = 4'd10;
    localparam logic [EVENT_W-1:0] EV_START1 = 4'd11;
    localparam logic [EVENT_W-1:0] EV_START2 = 4'd12;

    localparam logic [PATH_W-1:0] P_NULL = 4'd0;
    localparam logic [PATH_W-1:0] P_FLUSH = 4'd1;
    localparam logic [PATH_W-1:0] P_V15 = 4'd2;
    localparam logic [PATH_W-1:0] P_V2 = 4'd3;
    localparam logic [PATH_W-1:0] P_BC1_V15 = 4'd4;
    localparam logic [PATH_W-1:0] P_BC2_V15 = 4'd5;
    localparam logic [PATH_W-1:0] P_BC1_V1314 = 4'd6;
    localparam logic [PATH_W-1:0] P_BC2_V1314 = 4'd7;
    localparam logic [PATH_W-1:0] P_RINSE = 4'd8;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE     = 5'd0,
        ST_NC       = 5'd1,
        ST_OF_T     = 5'd2,
        ST_OF       = 5'd3,
        ST_V15_T    = 5'd4,
        ST_V15      = 5'd5,
        ST_V2_T     = 5'd6,
        ST_V2       = 5'd7,
        ST_BO1V4_T  = 5'd8,
        ST_BO1V4    = 5'd9,
        ST_BO2V4_T  = 5'd10,
        ST_BO2V4    = 5'd11,
        ST_BO1_T    = 5'd12,
        ST_BO1      = 5'd13,
        ST_BO2_T    = 5'd14,
        ST_BO2      = 5'd15,
        ST_STOP1    = 5'd16,
        ST_STOP2    = 5'd17,
        ST_BC1_T    = 5'd18,
        ST_BC2_T    = 5'd19,
        ST_DONE1    = 5'd20,
        ST_DONE2    = 5'd21
    } state_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_req;
        logic               command_ok;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] state_now;
        logic               path_valid;
        logic [PATH_W-1:0]  path_code;
        logic               valve_open_cmd;
        logic               valve_close_cmd;
        logic               pumps_run_cmd;
        logic               fill_done_request;
        logic               report_valid;
        logic [TICKS_W-1:0] report_fill_ticks;
        logic               report_chamber;
    } out_item_t;

    // flow path a state commands on resume; states past the table give null
    function automatic logic [PATH_W-1:0] path_of_state(input state_t s);
        logic [STATE_W-1:0] v;
        v = s;
        if (v[STATE_W-1])
        begin
            return P_NULL;
        end
        return {1'b0, v[3:1]};
    endfunction

endpackage

>>> rtl/balancing_chamber_sequencer.sv
// Balancing chamber sequencer.
// Each event passes the input register, then the result register, and is held in its
// register while the output side stalls.
// Throughput: one event per cycle unless the output side stalls; the next-state step is the limit.
// Reset (rst_n low, asynchronous): state idle, counters and wait flag cleared,
// open-fill limit back to 300 s, both pipeline stages empty.
module balancing_chamber_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bcs_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bcs_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [14:0]         cfg_data
);
    import bcs_pkg::*;

    logic                  in_valid_reg;
    in_item_t              in_data_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;
    out_item_t             out_data_next;

    state_t                state_reg, state_next;
    state_t                prev_reg, prev_next;
    logic                  half_reg, half_next;
    logic [STATE_W-1:0]    settle_reg, settle_next;
    logic [OPENFILL_W-1:0] openfill_reg, openfill_next;
    logic [TICKS_W-1:0]    fill_reg, fill_next;
    logic [TICKS_W-1:0]    limit_reg;

    logic                  advance;
    logic                  fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
            prev_reg      <= ST_IDLE;
            half_reg      <= 1'b0;
            settle_reg    <= '0;
            openfill_reg  <= '0;
            fill_reg      <= '0;
            limit_reg     <= OPENFILL_LIMIT_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                state_reg    <= state_next;
                prev_reg     <= prev_next;
                half_reg     <= half_next;
                settle_reg   <= settle_next;
                openfill_reg <= openfill_next;
                fill_reg     <= fill_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        logic [EVENT_W-1:0]    ev;
        logic                  ok;
        state_t                st;
        state_t                pst;
        logic                  hs;
        logic [STATE_W-1:0]    sc;
        logic [OPENFILL_W-1:0] ofc;
        logic [OPENFILL_W-1:0] was;
        logic [TICKS_W-1:0]    ft;
        logic                  pv, vo, vc, pr, fd, rv, rch;
        logic [PATH_W-1:0]     pc;
        logic [TICKS_W-1:0]    rticks;

        ev     = in_data_reg.event_req;
        ok     = in_data_reg.command_ok;
        st     = state_reg;
        pst    = prev_reg;
        hs     = half_reg;
        sc     = settle_reg;
        ofc    = openfill_reg;
        was    = openfill_reg;
        ft     = fill_reg;
        pv     = 1'b0;
        vo     = 1'b0;
        vc     = 1'b0;
        pr     = 1'b0;
        fd     = 1'b0;
        rv     = 1'b0;
        rch    = 1'b0;
        pc     = P_NULL;
        rticks = '0;

        if (ev == EV_START)
        begin
            pv  = 1'b1;
            pc  = P_FLUSH;
            pst = st;
            st  = ST_OF_T;
            vo  = (state_reg == ST_STOP1) || (state_reg == ST_STOP2);
        end
        else if (ev == EV_RESUME)
        begin
            pv = 1'b1;
            pc = path_of_state(prev_reg);
            st = prev_reg;
        end
        else if (ev == EV_STOP)
        begin
            pv = 1'b1;
            pc = P_RINSE;
            st = ST_IDLE;
        end

        unique case (st)
            ST_OF_T, ST_OF:
            begin
                if (st == ST_OF_T && ev == EV_T500MS)
                begin
                    hs = 1'b1;
                end
                else if (st == ST_OF_T && ev == EV_T1S)
                begin
                    if (hs)
                    begin
                        pst = st;
                        st  = ST_OF;
                        hs  = 1'b0;
                    end
                end
                else if (st == ST_OF && ev == EV_T1S)
                begin
                    if (ofc != OPENFILL_MAX)
                    begin
                        ofc = ofc + 16'd1;
                    end
                    if (was > {1'b0, limit_reg})
                    begin
                        ofc = '0;
                        pr  = 1'b1;
                        pv  = 1'b1;
                        pc  = P_BC1_V1314;
                        vc  = 1'b1;
                        fd  = 1'b1;
                        if (ok)
                        begin
                            pst = st;
                            st  = ST_BO1_T;
                        end
                    end
                end
                else if (ev == EV_STOP1 || ev == EV_STOP2)
                begin
                    ofc = '0;
                    pv  = 1'b1;
                    pc  = (ev == EV_STOP1) ? P_BC1_V1314 : P_BC2_V1314;
                    if (ok)
                    begin
                        pst = st;
                        st  = (ev == EV_STOP1) ? ST_STOP1 : ST_STOP2;
                    end
                end
            end
            ST_V15_T, ST_V2_T, ST_BO2V4_T:
            begin
                if (ev == EV_T500MS)
                begin
                    hs = 1'b1;
                end
                else if (ev == EV_T1S && hs)
                begin
                    pst = st;
                    st  = state_t'(st + 5'd1);
                    hs  = 1'b0;
                end
            end
            ST_BO1V4_T:
            begin
                if (ev == EV_T500MS)
                begin
                    pst = st;
                    st  = ST_BO1V4;
                    hs  = 1'b0;
                end
            end
            ST_BO1_T, ST_BO2_T:
            begin
                if (ev == EV_T50MS)
                begin
                    if (ft != FILL_MAX)
                    begin
                        ft = ft + 15'd1;
                    end
                    if (sc < SETTLE_TICKS)
                    begin
                        vc = (sc == SETTLE_CLOSE_AT);
                        sc = sc + 5'd1;
                    end
                    else
                    begin
                        sc  = '0;
                        pst = st;
                        st  = (st == ST_BO1_T) ? ST_BO1 : ST_BO2;
                    end
                end
            end
            ST_BO1, ST_BO2:
            begin
                if (ev == EV_T50MS)
                begin
                    if (ft != FILL_MAX)
                    begin
                        ft = ft + 15'd1;
                    end
                end
                else if (ev == EV_CURRENT)
                begin
                    rv     = 1'b1;
                    rticks = ft;
                    rch    = (st == ST_BO2);
                    pv     = 1'b1;
                    pc     = (st == ST_BO1) ? P_BC2_V1314 : P_BC1_V1314;
                    vo     = 1'b1;
                    if (ok)
                    begin
                        pst = st;
                        st  = (st == ST_BO1) ? ST_BO2_T : ST_BO1_T;
                        ft  = '0;
                    end
                end
            end
            ST_STOP1:
            begin
                if (ev == EV_START1)
                begin
                    pv = 1'b1;
                    pc = P_BC1_V1314;
                    st = ST_BC1_T;
                end
            end
            ST_STOP2:
            begin
                if (ev == EV_START2)
                begin
                    pv = 1'b1;
                    pc = P_BC2_V1314;
                    st = ST_BC2_T;
                end
            end
            default:
            begin
            end
        endcase

        state_next    = st;
        prev_next     = pst;
        half_next     = hs;
        settle_next   = sc;
        openfill_next = ofc;
        fill_next     = ft;

        out_data_next.state_now         = st;
        out_data_next.path_valid        = pv;
        out_data_next.path_code         = pc;
        out_data_next.valve_open_cmd    = vo;
        out_data_next.valve_close_cmd   = vc;
        out_data_next.pumps_run_cmd     = pr;
        out_data_next.fill_done_request = fd;
        out_data_next.report_valid      = rv;
        out_data_next.report_fill_ticks = rticks;
        out_data_next.report_chamber    = rch;
    end

`ifndef SYNTHESIS
    a_report_has_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.report_valid |-> out_data_reg.path_valid)
        else $error("fill report without flow path");

    a_pumps_end_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.pumps_run_cmd |->
            out_data_reg.fill_done_request && out_data_reg.valve_close_cmd &&
            out_data_reg.path_code == P_BC1_V1314)
        else $error("pump start not paired with end of open fill");

    a_null_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.path_valid |-> out_data_reg.path_code == P_NULL)
        else $error("path code without path command");

    a_settle_range: assert property (@(posedge clk) disable iff (!rst_n)
        settle_reg <= SETTLE_TICKS)
        else $error("settle counter out of range");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_stall |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage lost a stalled event");
`endif

endmodule

>>> verif/sequencer_checker.sv
`timescale 1ns / 1ps

module sequencer_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  bcs_pkg::in_item_t           in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  bcs_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [bcs_pkg::TICKS_W-1:0] cfg_data,
    output int                          errors,
    output int                          pending,
    output int                          checked,
    output int                          reports
);
    import bcs_pkg::*;

    state_t                 st;
    state_t                 prev_st;
    logic                   waited_half;
    logic [STATE_W-1:0]     settle;
    logic [OPENFILL_W-1:0]  of_secs;
    logic [TICKS_W-1:0]     fill;
    logic [TICKS_W-1:0]     of_limit;
    out_item_t              expected_q[$];

    task automatic flag_error(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic logic [PATH_W-1:0] resume_route(input state_t s);
        case (s)
            ST_OF_T, ST_OF:             return P_FLUSH;
            ST_V15_T, ST_V15:           return P_V15;
            ST_V2_T, ST_V2:             return P_V2;
            ST_BO1V4_T, ST_BO1V4:       return P_BC1_V15;
            ST_BO2V4_T, ST_BO2V4:       return P_BC2_V15;
            ST_BO1_T, ST_BO1:           return P_BC1_V1314;
            ST_BO2_T, ST_BO2:           return P_BC2_V1314;
            default:                    return P_NULL;
        endcase
    endfunction

    task automatic move_to(input state_t s);
        prev_st = st;
        st = s;
    endtask

    task automatic bump_fill();
        if (fill != FILL_MAX)
        begin
            fill = fill + 1'b1;
        end
    endtask

    task automatic settle_step(input state_t dest, output logic close_valve);
        close_valve = 1'b0;
        bump_fill();
        if (settle < SETTLE_TICKS)
        begin
            if (settle == SETTLE_CLOSE_AT)
            begin
                close_valve = 1'b1;
            end
            settle = settle + 1'b1;
        end
        else
        begin
            settle = '0;
            move_to(dest);
        end
    endtask

    task automatic step_sequencer(input in_item_t it, output out_item_t r);
        state_t                 entry;
        logic [EVENT_W-1:0]     ev;
        logic [OPENFILL_W-1:0]  secs_before;
        logic                   chamber_one;
        logic                   close_valve;
        r = '0;
        entry = st;
        ev = it.event_req;
        case (ev)
            EV_START:
            begin
                r.path_valid = 1'b1;
                r.path_code = P_FLUSH;
                move_to(ST_OF_T);
                if (entry == ST_STOP1 || entry == ST_STOP2)
                begin
                    r.valve_open_cmd = 1'b1;
                end
            end
            EV_RESUME:
            begin
                r.path_valid = 1'b1;
                r.path_code = resume_route(prev_st);
                st = prev_st;
            end
            EV_STOP:
            begin
                r.path_valid = 1'b1;
                r.path_code = P_RINSE;
                st = ST_IDLE;
            end
            default:
            begin
            end
        endcase

        case (st)
            ST_OF_T, ST_OF:
            begin
                if (st == ST_OF_T && ev == EV_T500MS)
                begin
                    waited_half = 1'b1;
                end
                else if (st == ST_OF_T && ev == EV_T1S)
                begin
                    if (waited_half)
                    begin
                        move_to(ST_OF);
                        waited_half = 1'b0;
                    end
                end
                else if (st == ST_OF && ev == EV_T1S)
                begin
                    secs_before = of_secs;
                    if (of_secs != OPENFILL_MAX)
                    begin
                        of_secs = of_secs + 1'b1;
                    end
                    if (secs_before > {1'b0, of_limit})
                    begin
                        of_secs = '0;
                        r.pumps_run_cmd = 1'b1;
                        r.path_valid = 1'b1;
                        r.path_code = P_BC1_V1314;
                        r.valve_close_cmd = 1'b1;
                        r.fill_done_request = 1'b1;
                        if (it.command_ok)
                        begin
                            move_to(ST_BO1_T);
                        end
                    end
                end
                else if (ev == EV_STOP1 || ev == EV_STOP2)
                begin
                    of_secs = '0;
                    r.path_valid = 1'b1;
                    r.path_code = (ev == EV_STOP1) ? P_BC1_V1314 : P_BC2_V1314;
                    if (it.command_ok)
                    begin
                        move_to((ev == EV_STOP1) ? ST_STOP1 : ST_STOP2);
                    end
                end
            end
            ST_V15_T, ST_V2_T, ST_BO2V4_T:
            begin
                if (ev == EV_T500MS)
                begin
                    waited_half = 1'b1;
                end
                else if (ev == EV_T1S && waited_half)
                begin
                    move_to(state_t'(st + 5'd1));
                    waited_half = 1'b0;
                end
            end
            ST_BO1V4_T:
            begin
                if (ev == EV_T500MS)
                begin
                    move_to(ST_BO1V4);
                    waited_half = 1'b0;
                end
            end
            ST_BO1_T, ST_BO2_T:
            begin
                if (ev == EV_T50MS)
                begin
                    settle_step((st == ST_BO1_T) ? ST_BO1 : ST_BO2, close_valve);
                    r.valve_close_cmd = close_valve;
                end
            end
            ST_BO1, ST_BO2:
            begin
                if (ev == EV_T50MS)
                begin
                    bump_fill();
                end
                else if (ev == EV_CURRENT)
                begin
                    chamber_one = (st == ST_BO1);
                    r.report_valid = 1'b1;
                    r.report_fill_ticks = fill;
                    r.report_chamber = !chamber_one;
                    r.path_valid = 1'b1;
                    r.path_code = chamber_one ? P_BC2_V1314 : P_BC1_V1314;
                    r.valve_open_cmd = 1'b1;
                    if (it.command_ok)
                    begin
                        move_to(chamber_one ? ST_BO2_T : ST_BO1_T);
                        fill = '0;
                    end
                end
            end
            ST_STOP1:
            begin
                if (ev == EV_START1)
                begin
                    r.path_valid = 1'b1;
                    r.path_code = P_BC1_V1314;
                    st = ST_BC1_T;
                end
            end
            ST_STOP2:
            begin
                if (ev == EV_START2)
                begin
                    r.path_valid = 1'b1;
                    r.path_code = P_BC2_V1314;
                    st = ST_BC2_T;
                end
            end
            default:
            begin
            end
        endcase
        r.state_now = st;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t next_result;
        if (!rst_n)
        begin
            st = ST_IDLE;
            prev_st = ST_IDLE;
            waited_half = 1'b0;
            settle = '0;
            of_secs = '0;
            fill = '0;
            of_limit = OPENFILL_LIMIT_RESET;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                of_limit = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    flag_error($sformatf("result with nothing expected, state_now %0d",
                                         out_data.state_now));
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.report_valid)
                    begin
                        reports++;
                    end
                    check_field("state_now", out_data.state_now, want.state_now);
                    check_field("path_valid", out_data.path_valid, want.path_valid);
                    check_field("path_code", out_data.path_code, want.path_code);
                    check_field("valve_open_cmd", out_data.valve_open_cmd,
                                want.valve_open_cmd);
                    check_field("valve_close_cmd", out_data.valve_close_cmd,
                                want.valve_close_cmd);
                    check_field("pumps_run_cmd", out_data.pumps_run_cmd,
                                want.pumps_run_cmd);
                    check_field("fill_done_request", out_data.fill_done_request,
                                want.fill_done_request);
                    check_field("report_valid", out_data.report_valid, want.report_valid);
                    check_field("report_fill_ticks", out_data.report_fill_ticks,
                                want.report_fill_ticks);
                    check_field("report_chamber", out_data.report_chamber,
                                want.report_chamber);
                end
            end
            if (in_valid && !in_stall)
            begin
                step_sequencer(in_data, next_result);
                expected_q.push_back(next_result);
            end
            pending = expected_q.size();
        end
    end

endmodule

>>> verif/balancing_chamber_sequencer_tb.sv
`timescale 1ns / 1ps

module balancing_chamber_sequencer_tb;
    import bcs_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [TICKS_W-1:0]     cfg_data;

    int                     errors;
    int                     pending;
    int                     checked;
    int                     reports;
    int                     sent;
    int                     holds_asked;
    int                     holds_done;
    int                     mid_limit;
    bit                     calm;

    balancing_chamber_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sequencer_checker seq_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .reports   (reports)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Run timed out with %0d results outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 23);
            end
        end
    end

    task automatic send_event(input logic [EVENT_W-1:0] ev, input logic ok);
        while (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{event_req: ev, command_ok: ok};
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_limit(input logic [TICKS_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic noise_burst(input int n);
        repeat (n)
        begin
            send_event(EVENT_W'($urandom_range(15)), $urandom_range(1) != 0);
        end
    endtask

    // start, open fill (past the limit only if it is at most 20), alternate the chambers one to four times, maybe stop
    task automatic run_session(input int lim);
        int opens;
        int rounds;
        logic first;
        send_event(EV_START, $urandom_range(1) != 0);
        if ($urandom_range(9) != 0)
        begin
            send_event(EV_T500MS, $urandom_range(1) != 0);
        end
        else
        begin
            noise_burst(1);
        end
        send_event(EV_T1S, $urandom_range(1) != 0);
        opens = (lim > 20) ? $urandom_range(20) : lim + 2;
        repeat (opens)
        begin
            send_event(EV_T1S, $urandom_range(99) < 90);
        end
        rounds = $urandom_range(1, 4);
        repeat (rounds)
        begin
            repeat ($urandom_range(17, 23)) send_event(EV_T50MS, $urandom_range(1) != 0);
            repeat ($urandom_range(12)) send_event(EV_T50MS, $urandom_range(1) != 0);
            if ($urandom_range(9) == 0)
            begin
                noise_burst(1);
            end
            send_event(EV_CURRENT, $urandom_range(99) < 85);
        end
        case ($urandom_range(3))
            0:
            begin
                send_event(EV_STOP, $urandom_range(1) != 0);
            end
            1:
            begin
                first = $urandom_range(1) != 0;
                send_event(first ? EV_STOP1 : EV_STOP2, $urandom_range(99) < 80);
                send_event(first ? EV_START1 : EV_START2, $urandom_range(1) != 0);
                send_event(EV_RESUME, $urandom_range(1) != 0);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic random_phase(input int lim, input int target);
        int base;
        base = sent;
        while (sent - base < target)
        begin
            if ($urandom_range(4) == 0)
            begin
                noise_burst($urandom_range(1, 8));
            end
            else
            begin
                run_session(lim);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored events, resume and stop from idle, stop/start of the
        // chambers, start from a stopped state, resume to states past the table
        send_event(EV_PAUSE, 1'b1);
        send_event(EV_RESET, 1'b1);
        send_event(4'd13, 1'b0);
        send_event(4'd14, 1'b1);
        send_event(4'd15, 1'b1);
        send_event(EV_RESUME, 1'b0);
        send_event(EV_STOP, 1'b0);
        send_event(EV_START, 1'b0);
        send_event(EV_T1S, 1'b1);
        send_event(EV_T500MS, 1'b1);
        send_event(EV_T1S, 1'b1);
        send_event(EV_STOP1, 1'b0);
        send_event(EV_STOP2, 1'b1);
        send_event(EV_START, 1'b1);
        send_event(EV_RESUME, 1'b1);
        send_event(EV_START1, 1'b1);
        send_event(EV_START2, 1'b0);
        send_event(EV_RESUME, 1'b1);
        send_event(EV_START, 1'b0);
        send_event(EV_STOP1, 1'b1);
        send_event(EV_START1, 1'b1);
        send_event(EV_START, 1'b1);
        send_event(EV_RESUME, 1'b1);
        send_event(EV_STOP, 1'b1);

        // full open fill at the reset limit, no idling on either side
        calm = 1'b1;
        send_event(EV_START, 1'b1);
        send_event(EV_T500MS, 1'b1);
        send_event(EV_T1S, 1'b1);
        repeat (302) send_event(EV_T1S, 1'b1);
        repeat (26) send_event(EV_T50MS, 1'b1);
        send_event(EV_CURRENT, 1'b1);
        calm = 1'b0;

        write_limit(15'd0);
        holds_asked++;
        random_phase(0, 200);

        write_limit(15'h7FFF);
        random_phase(32767, 80);

        mid_limit = $urandom_range(1, 6);
        write_limit(TICKS_W'(mid_limit));
        holds_asked++;
        random_phase(mid_limit, 200);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d results over %0d events, %0d of them chamber fill reports.",
                 checked, sent, reports);
        $display("Open-fill limits 300, 0, 32767 and %0d, with stalls and drained pauses.",
                 mid_limit);
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
